// ===== src/indexed_list_insert_delete_engine_unit_defines.svh =====
// assertion macros for the indexed list engine
// no dependencies; included by the top level
`ifndef INDEXED_LIST_INSERT_DELETE_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define ILIDE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define ILIDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ilide_pkg.sv =====
// shared types and constants of the indexed list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ilide_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_GET    = 3'd1,
    OP_SET    = 3'd2,
    OP_DELETE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CNT_W-1:0]  index;
    logic              at_end;
    logic [DATA_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]  count;
    logic              empty_res;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/ilide_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on ilide_pkg for the default width and depth
`timescale 1ns / 1ps
`default_nettype none

module ilide_ram
  import ilide_pkg::*;
#(
  parameter int unsigned WIDTH = DATA_W,
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [Aw-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/indexed_list_insert_delete_engine_unit.sv =====
// top level of the indexed list engine: control, count and apb register
// depends on ilide_pkg, ilide_ram and the assertion macro header
//
//  port group   | handshake            | payload
//  -------------+----------------------+------------------------------
//  input item   | in_valid_i/in_ready_o| in_item_i  (in_item_t)
//  result item  | out_valid_o/out_ready_i | out_item_o (out_item_t)
//  config       | psel/penable/pready  | paddr, pwdata, prdata
//
// one item at a time; get reads through S_GET, other ops without a shift
// go straight to S_DONE; insert and delete shift k entries in S_UP / S_DN,
// one entry per cycle through the single ram read and write port pair
// result register lets the next item be accepted while a result waits
// reset clears the count and sets capacity to 16; ram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_insert_delete_engine_unit_defines.svh"

module indexed_list_insert_delete_engine_unit
  import ilide_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_item_t           in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_item_t               out_item_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int unsigned Aw        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntMax    = (1 << CNT_W) - 1;
  localparam int unsigned DepthClip = (DEPTH > CntMax) ? CntMax : DEPTH;
  localparam logic [CNT_W-1:0] One  = CNT_W'(1);
  localparam logic [CNT_W-1:0] Two  = CNT_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_UP,
    S_UP_TAIL,
    S_FILL,
    S_DN,
    S_DN_TAIL,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  capacity_q, capacity_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  end_q, end_d;
  logic              pend_q, pend_d;
  logic              ok_q, ok_d;
  logic [DATA_W-1:0] wval_q, wval_d;
  logic [DATA_W-1:0] rval_q, rval_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              ram_we, ram_re;
  logic [Aw-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]  cap_use;
  logic [CNT_W-1:0]  pos_eff;
  logic              ins_ok, acc_ok;
  logic              cfg_wr;

  ilide_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

  // bounds decision on the incoming item
  assign cap_use = (capacity_q > CNT_W'(DepthClip)) ? CNT_W'(DepthClip) : capacity_q;

  always_comb begin
    if (in_item_i.operation == OP_INSERT) begin
      pos_eff = in_item_i.at_end ? count_q : in_item_i.index;
    end else begin
      pos_eff = in_item_i.at_end ? (count_q - One) : in_item_i.index;
    end
  end

  assign ins_ok = (pos_eff <= count_q) && (count_q < cap_use);
  assign acc_ok = !(in_item_i.at_end && (count_q == '0)) && (pos_eff < count_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    capacity_d  = capacity_q;
    pos_d       = pos_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    pend_d      = pend_q;
    ok_d        = ok_q;
    wval_d      = wval_q;
    rval_d      = rval_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (cfg_wr) begin
      capacity_d = pwdata[CNT_W-1:0];
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          wval_d  = in_item_i.write_value;
          pos_d   = pos_eff;
          rval_d  = '0;
          pend_d  = 1'b0;
          state_d = S_DONE;
          case (in_item_i.operation)
            OP_INSERT: begin
              ok_d = ins_ok;
              if (ins_ok) begin
                count_d = count_q + One;
                if (pos_eff == count_q) begin
                  ram_we    = 1'b1;
                  ram_waddr = Aw'(pos_eff);
                  ram_wdata = in_item_i.write_value;
                end else begin
                  ptr_d   = count_q - One;
                  state_d = S_UP;
                end
              end
            end
            OP_GET: begin
              ok_d = acc_ok;
              if (acc_ok) begin
                ram_re    = 1'b1;
                ram_raddr = Aw'(pos_eff);
                state_d   = S_GET;
              end
            end
            OP_SET: begin
              ok_d = acc_ok;
              if (acc_ok) begin
                ram_we    = 1'b1;
                ram_waddr = Aw'(pos_eff);
                ram_wdata = in_item_i.write_value;
              end
            end
            OP_DELETE: begin
              ok_d = acc_ok;
              if (acc_ok) begin
                count_d = count_q - One;
                if (pos_eff != count_q - One) begin
                  ptr_d   = pos_eff + One;
                  end_d   = count_q - One;
                  state_d = S_DN;
                end
              end
            end
            OP_CLEAR: begin
              ok_d    = 1'b1;
              count_d = '0;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      S_GET: begin
        rval_d  = ram_rdata;
        state_d = S_DONE;
      end
      S_UP: begin
        ram_re    = 1'b1;
        ram_raddr = Aw'(ptr_q);
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = Aw'(ptr_q + Two);
          ram_wdata = ram_rdata;
        end
        pend_d = 1'b1;
        if (ptr_q == pos_q) begin
          state_d = S_UP_TAIL;
        end else begin
          ptr_d = ptr_q - One;
        end
      end
      S_UP_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = Aw'(ptr_q + One);
        ram_wdata = ram_rdata;
        state_d   = S_FILL;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = Aw'(pos_q);
        ram_wdata = wval_q;
        state_d   = S_DONE;
      end
      S_DN: begin
        ram_re    = 1'b1;
        ram_raddr = Aw'(ptr_q);
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = Aw'(ptr_q - Two);
          ram_wdata = ram_rdata;
        end
        pend_d = 1'b1;
        if (ptr_q == end_q) begin
          state_d = S_DN_TAIL;
        end else begin
          ptr_d = ptr_q + One;
        end
      end
      S_DN_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = Aw'(ptr_q - One);
        ram_wdata = ram_rdata;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.ok         = ok_q;
          out_d.read_value = rval_q;
          out_d.count      = count_q;
          out_d.empty_res  = (count_q == '0);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      capacity_q  <= CAP_RESET;
      pos_q       <= '0;
      ptr_q       <= '0;
      end_q       <= '0;
      pend_q      <= 1'b0;
      ok_q        <= 1'b0;
      wval_q      <= '0;
      rval_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      capacity_q  <= capacity_d;
      pos_q       <= pos_d;
      ptr_q       <= ptr_d;
      end_q       <= end_d;
      pend_q      <= pend_d;
      ok_q        <= ok_d;
      wval_q      <= wval_d;
      rval_q      <= rval_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // checks
  `ILIDE_ASSERT_NOW(a_rw_disjoint, clk_i, rst_ni, ram_we && ram_re, ram_waddr != ram_raddr, "ram read and write hit the same entry")
  `ILIDE_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(DepthClip), "count beyond storage depth")
  `ILIDE_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, in_valid_i && in_ready_o && (in_item_i.operation == OP_INSERT) && ins_ok, count_q == $past(count_q) + One, "insert did not grow the count")
  `ILIDE_ASSERT_NOW(a_empty_flag, clk_i, rst_ni, out_valid_o, out_item_o.empty_res == (out_item_o.count == '0), "empty flag disagrees with count")

endmodule

`default_nettype wire
